FILE: rtl/bdlp_pkg.sv
package bdlp_pkg;

    // Field widths
    localparam int ACTION_W  = 2;
    localparam int BUTTON_W  = 3;
    localparam int LEVELS_W  = 5;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int STEP_W    = 10;
    localparam int TIME_W    = 16;
    localparam int SUM_W     = TIME_W + 1;

    // Defaults and sizes
    localparam int NUM_BUTTONS_DEF = 5;
    localparam int FIFO_DEPTH      = 2;

    localparam logic [STEP_W-1:0] TICK_STEP_RST = STEP_W'(10);
    localparam logic [TIME_W-1:0] REPEAT_RST    = TIME_W'(500);
    localparam logic [TIME_W-1:0] HOLD_RST      = TIME_W'(3000);

    // Input actions
    localparam logic [ACTION_W-1:0] ACT_EDGE     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEBOUNCE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;

    // Event kinds
    localparam logic [KIND_W-1:0] EV_PRESSED  = 2'd0;
    localparam logic [KIND_W-1:0] EV_RELEASED = 2'd1;
    localparam logic [KIND_W-1:0] EV_REPEAT   = 2'd2;
    localparam logic [KIND_W-1:0] EV_HOLD     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd2;

    // Held event waiting for its last flag
    typedef struct packed {
        logic                valid;
        logic [BUTTON_W-1:0] btn;
        logic [KIND_W-1:0]   kind;
    } ev_slot_t;

endpackage

FILE: rtl/bdlp_front.sv
module bdlp_front #(
    parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF,
    parameter int DATA_W      = 1 + bdlp_pkg::LEVELS_W + NUM_BUTTONS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bdlp_pkg::ACTION_W-1:0] action,
    input  logic [bdlp_pkg::BUTTON_W-1:0] button,
    input  logic [bdlp_pkg::LEVELS_W-1:0] levels,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [DATA_W-1:0]             q_data
);
    import bdlp_pkg::*;

    logic [NUM_BUTTONS-1:0] pending_reg, pending_next;
    logic                   armed_reg, armed_next;
    logic [NUM_BUTTONS-1:0] edge_set;
    logic                   accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // One-hot decode of the edge button; out-of-range buttons set nothing
    always_comb
    begin
        for (int g = 0; g < NUM_BUTTONS; g++)
        begin
            edge_set[g] = (32'(button) == 32'(g));
        end
    end

    // Classify: edges stay here, debounce snapshots and clears the marks,
    // ticks pass only once armed
    always_comb
    begin
        pending_next = pending_reg;
        armed_next   = armed_reg;
        q_push       = 1'b0;
        q_data       = {1'b0, levels, pending_reg};
        if (accept)
        begin
            case (action)
                ACT_EDGE:
                begin
                    pending_next = pending_reg | edge_set;
                    armed_next   = 1'b1;
                end
                ACT_DEBOUNCE:
                begin
                    if (pending_reg != '0)
                    begin
                        q_push       = 1'b1;
                        pending_next = '0;
                    end
                end
                ACT_TICK:
                begin
                    q_push = armed_reg;
                    q_data = {1'b1, levels, {NUM_BUTTONS{1'b0}}};
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            armed_reg   <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            armed_reg   <= armed_next;
        end
    end

endmodule

FILE: rtl/bdlp_fifo.sv
module bdlp_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);
    import bdlp_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;

    assign full     = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/bdlp_rem.sv
module bdlp_rem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bdlp_pkg::SUM_W-1:0]  dividend,
    input  logic [bdlp_pkg::TIME_W-1:0] divisor,
    output logic                        busy,
    output logic [bdlp_pkg::TIME_W-1:0] rem
);
    import bdlp_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] dsr_reg;
    logic [SUM_W-1:0]  trial;
    logic [SUM_W-1:0]  trial_sub;

    assign busy = busy_reg;
    assign rem  = rem_reg;

    // Restoring remainder, one dividend bit per cycle
    assign trial     = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(SUM_W);
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            rem_reg <= (trial >= {1'b0, dsr_reg}) ? trial_sub[TIME_W-1:0]
                                                  : trial[TIME_W-1:0];
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/bdlp_back.sv
module bdlp_back #(
    parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF,
    parameter int DATA_W      = 1 + bdlp_pkg::LEVELS_W + NUM_BUTTONS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // queue side
    input  logic                           q_empty,
    input  logic [DATA_W-1:0]              q_data,
    output logic                           q_pop,
    // configuration
    input  logic                           cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdlp_pkg::CFG_W-1:0]     cfg_data,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bdlp_pkg::BUTTON_W-1:0]  which_button,
    output logic [bdlp_pkg::KIND_W-1:0]    event_kind,
    output logic                           last
);
    import bdlp_pkg::*;

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BUTTONS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_EMIT,
        S_DONE
    } state_t;

    // Configuration registers
    logic [STEP_W-1:0] step_reg;
    logic [TIME_W-1:0] repeat_reg;
    logic [TIME_W-1:0] hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= TICK_STEP_RST;
            repeat_reg <= REPEAT_RST;
            hold_reg   <= HOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TICK_STEP: step_reg   <= cfg_data[STEP_W-1:0];
                CFG_REPEAT:    repeat_reg <= cfg_data[TIME_W-1:0];
                CFG_HOLD:      hold_reg   <= cfg_data[TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // FSM, per-button times, holdback slot and output register
    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   is_tick_reg;
    logic [LEVELS_W-1:0]    levels_reg;
    logic [NUM_BUTTONS-1:0] mask_reg;
    logic                   hold_hit_reg, hold_hit_next;
    logic [TIME_W-1:0]      held_reg  [NUM_BUTTONS];
    logic [TIME_W-1:0]      phase_reg [NUM_BUTTONS];
    ev_slot_t               hb_reg, hb_next;
    logic                   out_valid_reg, out_valid_next;
    logic [BUTTON_W-1:0]    out_btn_reg, out_btn_next;
    logic [KIND_W-1:0]      out_kind_reg, out_kind_next;
    logic                   out_last_reg, out_last_next;

    logic                   held_we, phase_we;
    logic [TIME_W-1:0]      held_wr, phase_wr;
    logic                   ev_fire, end_fire, adv;
    logic [KIND_W-1:0]      ev_kind;
    logic [BUTTON_W-1:0]    ev_btn;
    logic                   out_free, can_emit;

    // Shared remainder unit
    logic                   div_start, div_busy;
    logic [TIME_W-1:0]      div_rem;

    // Per-button datapath
    logic [NUM_BUTTONS-1:0] pressed_vec;
    logic                   pressed_cur;
    logic [TIME_W-1:0]      held_cur, phase_cur;
    logic [SUM_W-1:0]       held_sum, phase_sum, phase_sub, rep_ext;
    logic [TIME_W-1:0]      held_new;
    logic                   hold_now;
    logic [31:0]            idx_ext;

    genvar g;
    generate
        for (g = 0; g < NUM_BUTTONS; g++)
        begin : g_pressed
            if (g < LEVELS_W)
            begin : g_lvl
                assign pressed_vec[g] = levels_reg[g];
            end
            else
            begin : g_none
                assign pressed_vec[g] = 1'b0;
            end
        end
    endgenerate

    assign pressed_cur = pressed_vec[idx_reg];
    assign held_cur    = held_reg[idx_reg];
    assign phase_cur   = phase_reg[idx_reg];
    assign idx_ext     = 32'(idx_reg);
    assign ev_btn      = idx_ext[BUTTON_W-1:0];

    assign held_sum  = {1'b0, held_cur} + SUM_W'(step_reg);
    assign held_new  = held_sum[TIME_W] ? {TIME_W{1'b1}} : held_sum[TIME_W-1:0];
    assign hold_now  = (held_sum == {1'b0, hold_reg});
    assign rep_ext   = {1'b0, repeat_reg};
    assign phase_sum = {1'b0, phase_cur} + SUM_W'(step_reg);
    assign phase_sub = phase_sum - rep_ext;

    assign out_free = !out_valid_reg || out_ready;
    assign can_emit = !hb_reg.valid || out_free;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;

    bdlp_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (phase_sum),
        .divisor  (repeat_reg),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    // Sequencer: one button per step, events one per cycle while the output is not stalled
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        hold_hit_next = hold_hit_reg;
        held_we       = 1'b0;
        phase_we      = 1'b0;
        held_wr       = '0;
        phase_wr      = '0;
        ev_fire       = 1'b0;
        ev_kind       = EV_PRESSED;
        end_fire      = 1'b0;
        adv           = 1'b0;
        div_start     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (can_emit)
                begin
                    if (!is_tick_reg)
                    begin
                        // debounce: report level of each pending button
                        ev_fire = mask_reg[idx_reg];
                        ev_kind = pressed_cur ? EV_PRESSED : EV_RELEASED;
                        adv     = 1'b1;
                    end
                    else if (pressed_cur)
                    begin
                        held_we = 1'b1;
                        held_wr = held_new;
                        if (repeat_reg == '0)
                        begin
                            phase_we = 1'b1;
                            ev_fire  = hold_now;
                            ev_kind  = EV_HOLD;
                            adv      = 1'b1;
                        end
                        else if (phase_sum < rep_ext || phase_sub < rep_ext)
                        begin
                            // phase wraps at most once
                            phase_we = 1'b1;
                            phase_wr = (phase_sum < rep_ext) ? phase_sum[TIME_W-1:0]
                                                             : phase_sub[TIME_W-1:0];
                            if (phase_wr == '0)
                            begin
                                ev_fire = 1'b1;
                                ev_kind = EV_REPEAT;
                                if (hold_now)
                                begin
                                    hold_hit_next = 1'b1;
                                    state_next    = S_EMIT;
                                end
                                else
                                begin
                                    adv = 1'b1;
                                end
                            end
                            else
                            begin
                                ev_fire = hold_now;
                                ev_kind = EV_HOLD;
                                adv     = 1'b1;
                            end
                        end
                        else
                        begin
                            // phase far past the interval: full remainder
                            div_start     = 1'b1;
                            hold_hit_next = hold_now;
                            state_next    = S_DIV;
                        end
                    end
                    else
                    begin
                        // released: clear times
                        held_we  = 1'b1;
                        phase_we = 1'b1;
                        adv      = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                if (!div_busy && can_emit)
                begin
                    phase_we = 1'b1;
                    phase_wr = div_rem;
                    if (div_rem == '0)
                    begin
                        ev_fire = 1'b1;
                        ev_kind = EV_REPEAT;
                        if (hold_hit_reg)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            adv = 1'b1;
                        end
                    end
                    else
                    begin
                        ev_fire       = hold_hit_reg;
                        ev_kind       = EV_HOLD;
                        hold_hit_next = 1'b0;
                        adv           = 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (can_emit)
                begin
                    ev_fire       = 1'b1;
                    ev_kind       = EV_HOLD;
                    hold_hit_next = 1'b0;
                    adv           = 1'b1;
                end
            end
            S_DONE:
            begin
                // release the held event with its last flag
                if (!hb_reg.valid)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    end_fire   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv)
        begin
            if (idx_reg == IDX_LAST)
            begin
                state_next = S_DONE;
            end
            else
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_SCAN;
            end
        end
    end

    // Holdback slot and output register
    always_comb
    begin
        hb_next        = hb_reg;
        out_valid_next = out_valid_reg;
        out_btn_next   = out_btn_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;

        if ((ev_fire || end_fire) && hb_reg.valid)
        begin
            out_valid_next = 1'b1;
            out_btn_next   = hb_reg.btn;
            out_kind_next  = hb_reg.kind;
            out_last_next  = end_fire;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (ev_fire)
        begin
            hb_next.valid = 1'b1;
            hb_next.btn   = ev_btn;
            hb_next.kind  = ev_kind;
        end
        else if (end_fire)
        begin
            hb_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            is_tick_reg   <= 1'b0;
            levels_reg    <= '0;
            mask_reg      <= '0;
            hold_hit_reg  <= 1'b0;
            hb_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_btn_reg   <= '0;
            out_kind_reg  <= '0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                held_reg[i]  <= '0;
                phase_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            hold_hit_reg  <= hold_hit_next;
            hb_reg        <= hb_next;
            out_valid_reg <= out_valid_next;
            out_btn_reg   <= out_btn_next;
            out_kind_reg  <= out_kind_next;
            out_last_reg  <= out_last_next;
            if (q_pop)
            begin
                is_tick_reg <= q_data[DATA_W-1];
                levels_reg  <= q_data[DATA_W-2 -: LEVELS_W];
                mask_reg    <= q_data[NUM_BUTTONS-1:0];
            end
            if (held_we)
            begin
                held_reg[idx_reg] <= held_wr;
            end
            if (phase_we)
            begin
                phase_reg[idx_reg] <= phase_wr;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign which_button = out_btn_reg;
    assign event_kind   = out_kind_reg;
    assign last         = out_last_reg;

endmodule

FILE: rtl/button_debounce_long_press_top.sv
// Button qualifier for NUM_BUTTONS push buttons with debounce, auto-repeat and
// long-hold events. Edge requests are absorbed in the front and never occupy
// the back end; debounce and tick requests pass through a two-entry queue to
// the back end, which walks the buttons one per cycle while the output is not
// stalled, with an extra step through S_EMIT for each button that fires both a
// repeat and a hold event. When phase plus step reaches twice repeat_ms or more
// (only after repeat_ms is lowered, or when the step exceeds the interval) that
// button waits on the shared bit-serial remainder unit. Events leave through an
// output register, held one event back so that the final event of each request
// carries last = 1. Configuration writes must only happen while no request is
// in flight.
module button_debounce_long_press_top #(
    parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bdlp_pkg::ACTION_W-1:0]  action,
    input  logic [bdlp_pkg::BUTTON_W-1:0]  button,
    input  logic [bdlp_pkg::LEVELS_W-1:0]  levels,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bdlp_pkg::BUTTON_W-1:0]  which_button,
    output logic [bdlp_pkg::KIND_W-1:0]    event_kind,
    output logic                           last,
    input  logic                           cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdlp_pkg::CFG_W-1:0]     cfg_data
);
    import bdlp_pkg::*;

    localparam int DATA_W = 1 + LEVELS_W + NUM_BUTTONS;

    logic              q_push, q_pop, q_full, q_empty;
    logic [DATA_W-1:0] q_in_data, q_out_data;

    // Front: edge bookkeeping and classification
    bdlp_front #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .DATA_W      (DATA_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .button   (button),
        .levels   (levels),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in_data)
    );

    // Request queue
    bdlp_fifo #(
        .DATA_W (DATA_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in_data),
        .pop       (q_pop),
        .pop_data  (q_out_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back: per-button sequencing and event output
    bdlp_back #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .DATA_W      (DATA_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_out_data),
        .q_pop        (q_pop),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .which_button (which_button),
        .event_kind   (event_kind),
        .last         (last)
    );

endmodule

FILE: rtl/bdlp_checker.sv
module bdlp_checker #(
    parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [bdlp_pkg::ACTION_W-1:0]  action,
    input logic [bdlp_pkg::BUTTON_W-1:0]  button,
    input logic [bdlp_pkg::LEVELS_W-1:0]  levels,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [bdlp_pkg::BUTTON_W-1:0]  which_button,
    input logic [bdlp_pkg::KIND_W-1:0]    event_kind,
    input logic                           last,
    input logic                           cfg_we,
    input logic [bdlp_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [bdlp_pkg::CFG_W-1:0]     cfg_data
);
    import bdlp_pkg::*;

    logic seen_reg;

    // Any request taken since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            seen_reg <= 1'b1;
        end
    end

    // Stalled event holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(which_button)
            && $stable(event_kind) && $stable(last))
        else $error("event changed while stalled");

    // Events name an existing button
    a_btn_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(which_button) < NUM_BUTTONS))
        else $error("event for nonexistent button");

    // Repeat and hold only for buttons with a level input
    a_tick_btn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == EV_REPEAT || event_kind == EV_HOLD)
            |-> (32'(which_button) < LEVELS_W))
        else $error("timed event for button without level");

    // No event before any request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_reg)
        else $error("event without request");

    // Unused port bits in this checker
    logic unused_ok;
    assign unused_ok = ^{action, button, levels, cfg_we, cfg_index, cfg_data};

endmodule

bind button_debounce_long_press_top bdlp_checker #(
    .NUM_BUTTONS (NUM_BUTTONS)
) u_bdlp_checker (.*);
